// ===== hdl/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

    // Default datapath width and the modulus that reset loads
    localparam int          WIDTH_DEFAULT = 63;
    localparam logic [63:0] MODULUS_RESET = 64'd3000000000000000007;

    // Configuration port
    localparam int          PADDR_W      = 4;
    localparam int          PDATA_W      = 64;
    localparam logic [PADDR_W-1:0] ADDR_MODULUS = 4'h0;

endpackage

`default_nettype wire

// ===== hdl/modular_exponentiation_core.sv =====
// Modular exponentiation core: returns base ** exponent mod modulus by
// right-to-left binary square-and-multiply, every product reduced exactly.
// The modulus sits in a WIDTH-bit APB register at byte address 0 (reset value
// 3000000000000000007); write it only while the core is idle. A modulus of
// 0 or 1 gives a result of 0. All products go through one shared
// shift-add-reduce multiplier that retires one multiplier bit per cycle. An
// item costs one reduction of the base, then a squaring for every exponent
// bit below the highest set bit and a multiply for every set bit; an exponent
// of zero needs only the reduction.
// One item is worked on at a time; the input is stalled meanwhile, and the
// next item is taken while the previous result still waits at the output.
`default_nettype none

module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // input items
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [WIDTH-1:0]   base,
    input  wire logic [WIDTH-1:0]   exponent,
    // result items
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [WIDTH-1:0]   power_mod
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_FIN
    } state_t;

    localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] modulus_reg, modulus_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic [WIDTH-1:0] sq_reg, sq_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] op_a_reg, op_a_next;
    logic [WIDTH-1:0] op_b_reg, op_b_next;
    logic             start_reg, start_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;

    logic             mm_done;
    logic [WIDTH-1:0] mm_res;
    logic             cfg_wr;

    // Shared modular multiplier
    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .m      (modulus_reg),
        .done   (mm_done),
        .result (mm_res)
    );

    // Register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MODULUS);
    assign prdata = (paddr == ADDR_MODULUS) ? PDATA_W'(modulus_reg) : '0;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        modulus_next   = cfg_wr ? pwdata[WIDTH-1:0] : modulus_reg;
        exp_next       = exp_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    exp_next = exponent;
                    if (modulus_reg < WIDTH'(2))
                    begin
                        // degenerate modulus
                        acc_next   = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        // reduce the base: 1 * base mod m
                        op_a_next  = ONE;
                        op_b_next  = base;
                        start_next = 1'b1;
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (mm_done)
                begin
                    sq_next  = mm_res;
                    acc_next = ONE;
                    if (exp_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else if (exp_reg[0])
                    begin
                        op_a_next  = ONE;
                        op_b_next  = mm_res;
                        start_next = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        op_a_next  = mm_res;
                        op_b_next  = mm_res;
                        start_next = 1'b1;
                        state_next = S_SQR;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    acc_next = mm_res;
                    if (exp_reg[WIDTH-1:1] == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        op_a_next  = sq_reg;
                        op_b_next  = sq_reg;
                        start_next = 1'b1;
                        state_next = S_SQR;
                    end
                end
            end
            S_SQR:
            begin
                // higher exponent bits are always left here
                if (mm_done)
                begin
                    sq_next    = mm_res;
                    exp_next   = {1'b0, exp_reg[WIDTH-1:1]};
                    start_next = 1'b1;
                    if (exp_reg[1])
                    begin
                        op_a_next  = acc_reg;
                        op_b_next  = mm_res;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        op_a_next  = mm_res;
                        op_b_next  = mm_res;
                        state_next = S_SQR;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= MODULUS_RESET[WIDTH-1:0];
            exp_reg       <= '0;
            sq_reg        <= '0;
            acc_reg       <= '0;
            op_a_reg      <= '0;
            op_b_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            exp_reg       <= exp_next;
            sq_reg        <= sq_next;
            acc_reg       <= acc_next;
            op_a_reg      <= op_a_next;
            op_b_reg      <= op_b_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign power_mod = out_data_reg;

    // Assertions
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == S_RED || state_reg == S_MUL || state_reg == S_SQR))
        else $error("multiplier started outside a working state");

    a_product_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (mm_res < modulus_reg))
        else $error("product not reduced below the modulus");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (modulus_reg >= WIDTH'(2))) |-> (out_data_reg < modulus_reg))
        else $error("result not below the modulus");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

endmodule

`default_nettype wire

// ===== hdl/mexp_mulmod.sv =====
`default_nettype none

// Shift-add-reduce modular multiplier: result = (a * b) mod m.
// a must be below m; b may take any value. One multiplier bit per cycle,
// most significant first.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic [WIDTH-1:0] m,
    output logic                  done,
    output logic      [WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   dbl;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] sum_red;
    logic [WIDTH:0]   m_ext;

    // One step: double and reduce, then add a where the bit is set and reduce
    always_comb
    begin
        m_ext   = {1'b0, m};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? WIDTH'(dbl - m_ext) : dbl[WIDTH-1:0];
        sum     = {1'b0, dbl_red} + (b_reg[WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= m_ext) ? WIDTH'(sum - m_ext) : sum[WIDTH-1:0];
    end

    // Sequencing of the steps
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = CNT_W'(WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red;
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire
